// File: src/mzr_pkg.sv
`default_nettype none

package mzr_pkg;

    localparam int ALPHABET_SIZE     = 256;
    localparam int DEF_BLOCK_SIZE    = 32768;

    localparam int SYM_W             = 8;
    localparam int ROT_W             = 15;
    localparam int PI_W              = 15;
    localparam int RC_W              = 16;
    localparam int RUN_W             = 16;
    localparam int IN_TDATA_W        = 24;
    localparam int OUT_TDATA_W       = 40;

    localparam logic [RUN_W-1:0] RUN_LIMIT   = 16'd65534;
    localparam logic [RC_W-1:0]  COUNT_LIMIT = 16'd65535;
    localparam logic [ROT_W-1:0] PRIMARY_ROT = 15'd1;
    localparam logic [SYM_W-1:0] ESC_BYTE    = 8'd255;
    localparam logic [SYM_W-1:0] ESC_RANK    = 8'd254;

    typedef logic [SYM_W-1:0] t_sym;

    // control from sequencer to the cell row
    typedef struct packed {
        logic capture;  // latch per-cell match against the incoming symbol
        logic shift;    // move-to-front: cells 1..rank take their left neighbor, cell 0 the symbol
        logic clear;    // reload identity at block end
    } t_row_ctrl;

    typedef struct packed {
        logic front_hit;
        t_sym rank;
    } t_row_stat;

endpackage

`default_nettype wire

// File: src/mzr_cell.sv
`default_nettype none

module mzr_cell (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  mzr_pkg::t_row_ctrl i_ctrl,
    input  mzr_pkg::t_sym     i_index,
    input  mzr_pkg::t_sym     i_sym,
    input  mzr_pkg::t_sym     i_prev,
    input  mzr_pkg::t_sym     i_rank,
    output mzr_pkg::t_sym     o_entry,
    output logic              o_hit
);
    import mzr_pkg::*;

    t_sym r_entry;
    logic r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= i_index;
        end else if (i_ctrl.clear) begin
            r_entry <= i_index;
        end else if (i_ctrl.shift && (i_index <= i_rank)) begin
            r_entry <= i_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_hit <= (r_entry == i_sym);
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

`default_nettype wire

// File: src/mzr_row.sv
`default_nettype none

module mzr_row (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  mzr_pkg::t_row_ctrl i_ctrl,
    input  mzr_pkg::t_sym      i_sym,
    output mzr_pkg::t_row_stat o_stat
);
    import mzr_pkg::*;

    t_sym                     w_entry [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] w_hit;
    t_sym                     w_rank;

    for (genvar g = 0; g < ALPHABET_SIZE; g++) begin : g_cell
        t_sym w_prev;
        if (g == 0) begin : g_head
            assign w_prev = i_sym;
        end else begin : g_body
            assign w_prev = w_entry[g-1];
        end
        mzr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (i_ctrl),
            .i_index (SYM_W'(g)),
            .i_sym   (i_sym),
            .i_prev  (w_prev),
            .i_rank  (w_rank),
            .o_entry (w_entry[g]),
            .o_hit   (w_hit[g])
        );
    end

    // table is a permutation, so the hit vector is one-hot: plain OR encode
    always_comb begin
        w_rank = '0;
        for (int k = 0; k < ALPHABET_SIZE; k++) begin
            if (w_hit[k]) begin
                w_rank = w_rank | SYM_W'(k);
            end
        end
    end

    assign o_stat.front_hit = w_hit[0];
    assign o_stat.rank      = w_rank;

    a_hit_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_ctrl.capture) |-> $onehot(w_hit))
        else $error("match vector not one-hot after capture");

    a_front_after_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_ctrl.shift) && !$past(i_ctrl.clear) |-> w_entry[0] == $past(i_sym))
        else $error("shifted symbol did not land at the front");

    a_front_rank_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_ctrl.capture) && w_hit[0] |-> w_rank == '0)
        else $error("front hit with nonzero rank");

endmodule

`default_nettype wire

// File: src/mtf_zero_run_encoder.sv
// Move-to-front coder with zero-run coding of front hits.
// Input stream: one BWT last-column byte per transfer with its rotation index;
// tlast marks the final byte of a block. Output stream: one coded byte per
// transfer; tlast marks the last byte caused by an input item, tuser[0] the
// last byte of the block, which alone carries primary index and run count.
// Sequence: an item is taken, then looked up (rank encode across the 256-cell
// row and the shift), then its results leave one per cycle from the output
// register while the receiver is ready. An item yields 0 to 17 result bytes;
// a front hit that ends no block yields none. The first result passes the
// EVAL and EMIT states on its way into the output register.
// The input side is taken again as soon as the last result is in the output
// register, so the next item overlaps a stalled last result. A receiver stall
// holds the output register and pauses the result sequence.
// Reset: the table returns to identity, counters clear, no output is valid.
// Block end (tlast, or position BLOCK_SIZE-1) reloads the same state.
`default_nettype none

module mtf_zero_run_encoder #(
    parameter int BLOCK_SIZE = mzr_pkg::DEF_BLOCK_SIZE
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_s_tvalid,
    output logic                            o_s_tready,
    // [7:0] symbol, [22:8] rotation_index, [23] zero
    input  wire  [mzr_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // block_end
    input  wire                             i_s_tlast,
    output logic                            o_m_tvalid,
    input  wire                             i_m_tready,
    // [7:0] out_byte, [22:8] primary_index, [38:23] run_count, [39] zero
    output logic [mzr_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    // last_of_item
    output logic                            o_m_tlast,
    // [0] end_of_block
    output logic [0:0]                      o_m_tuser
);
    import mzr_pkg::*;

    localparam int POS_W = $clog2(BLOCK_SIZE);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_SIZE - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    function automatic logic [RC_W-1:0] sat_inc(input logic [RC_W-1:0] v);
        sat_inc = (v < COUNT_LIMIT) ? v + 16'd1 : v;
    endfunction

    logic [1:0]       r_state;
    t_sym             r_sym;
    logic             r_last;
    logic [POS_W-1:0] r_pos;
    logic [RUN_W-1:0] r_run;
    logic [PI_W-1:0]  r_primary;
    logic [RC_W-1:0]  r_runs;

    // result sequencer
    logic [RUN_W-1:0] r_v;
    logic             r_dig_act;
    logic [1:0]       r_tail;
    logic             r_esc;
    t_sym             r_rank;
    logic             r_end;
    logic [PI_W-1:0]  r_end_pi;
    logic [RC_W-1:0]  r_end_rc;

    // output register
    logic             r_o_valid;
    t_sym             r_o_byte;
    logic             r_o_last;
    logic             r_o_eob;
    logic [PI_W-1:0]  r_o_pi;
    logic [RC_W-1:0]  r_o_rc;

    t_sym             w_in_sym;
    logic [ROT_W-1:0] w_in_rot;
    logic             w_s_acc;
    logic             w_eval;
    logic             w_out_free;
    logic             w_step;
    logic [31:0]      w_pos_ext;
    logic [RUN_W-1:0] w_run_inc;
    logic [RC_W-1:0]  w_runs_a;
    logic [RC_W-1:0]  w_runs_fin;
    logic             w_escape;
    logic [RUN_W-1:0] w_v_next;
    logic             w_more;
    logic             w_final;
    t_sym             w_byte;
    t_sym             w_row_sym;
    t_row_ctrl        w_ctrl;
    t_row_stat        w_stat;

    assign w_in_sym   = i_s_tdata[SYM_W-1:0];
    assign w_in_rot   = i_s_tdata[SYM_W+ROT_W-1:SYM_W];
    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_acc    = i_s_tvalid && o_s_tready;
    assign w_eval     = (r_state == S_EVAL);
    assign w_out_free = !r_o_valid || i_m_tready;
    assign w_step     = (r_state == S_EMIT) && w_out_free;
    assign w_pos_ext  = 32'(r_pos);

    assign w_run_inc  = (r_run < RUN_LIMIT) ? r_run + 16'd1 : r_run;
    assign w_runs_a   = (r_run != '0) ? sat_inc(r_runs) : r_runs;
    assign w_runs_fin = w_stat.front_hit ? sat_inc(r_runs) : sat_inc(w_runs_a);
    assign w_escape   = (w_stat.rank >= ESC_RANK);

    assign w_row_sym      = w_s_acc ? w_in_sym : r_sym;
    assign w_ctrl.capture = w_s_acc;
    assign w_ctrl.shift   = w_eval && !w_stat.front_hit && !r_last;
    assign w_ctrl.clear   = w_eval && r_last;

    mzr_row u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_sym   (w_row_sym),
        .o_stat  (w_stat)
    );

    // next result byte: run digits LSB first, then the rank (escaped if high)
    always_comb begin
        w_v_next = r_v >> 1;
        w_more   = 1'b0;
        w_final  = 1'b0;
        if (r_dig_act) begin
            w_byte  = {{(SYM_W-1){1'b0}}, r_v[0]};
            w_more  = (w_v_next > 16'd1);
            w_final = !w_more && (r_tail == 2'd0);
        end else if (r_tail == 2'd2) begin
            w_byte = ESC_BYTE;
        end else begin
            w_byte  = r_esc ? r_rank : r_rank + 8'd1;
            w_final = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_run     <= '0;
            r_primary <= '0;
            r_runs    <= '0;
            r_dig_act <= 1'b0;
            r_tail    <= 2'd0;
            r_end     <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_s_acc) begin
                        if (w_in_rot == PRIMARY_ROT) begin
                            r_primary <= w_pos_ext[PI_W-1:0];
                        end
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (w_stat.front_hit) begin
                        r_run     <= r_last ? '0 : w_run_inc;
                        r_v       <= w_run_inc + 16'd1;
                        r_dig_act <= r_last;
                        r_tail    <= 2'd0;
                        r_state   <= r_last ? S_EMIT : S_IDLE;
                    end else begin
                        r_run     <= '0;
                        r_runs    <= r_last ? '0 : w_runs_fin;
                        r_v       <= r_run + 16'd1;
                        r_dig_act <= (r_run != '0);
                        r_tail    <= w_escape ? 2'd2 : 2'd1;
                        r_esc     <= w_escape;
                        r_rank    <= w_stat.rank;
                        r_state   <= S_EMIT;
                    end
                    if (r_last) begin
                        r_end     <= 1'b1;
                        r_end_pi  <= r_primary;
                        r_end_rc  <= w_runs_fin;
                        r_pos     <= '0;
                        r_primary <= '0;
                        if (w_stat.front_hit) begin
                            r_runs <= '0;
                        end
                    end else begin
                        r_end <= 1'b0;
                        r_pos <= r_pos + POS_W'(1);
                    end
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        if (r_dig_act) begin
                            r_v       <= w_v_next;
                            r_dig_act <= w_more;
                        end else begin
                            r_tail <= r_tail - 2'd1;
                        end
                        if (w_final) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_sym  <= w_in_sym;
            r_last <= i_s_tlast || (r_pos == POS_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_step) begin
            r_o_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_o_byte <= w_byte;
            r_o_last <= w_final;
            r_o_eob  <= w_final && r_end;
            r_o_pi   <= (w_final && r_end) ? r_end_pi : '0;
            r_o_rc   <= (w_final && r_end) ? r_end_rc : '0;
        end
    end

    assign o_m_tvalid   = r_o_valid;
    assign o_m_tdata    = {1'b0, r_o_rc, r_o_pi, r_o_byte};
    assign o_m_tlast    = r_o_last;
    assign o_m_tuser[0] = r_o_eob;

    a_eob_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tlast)
        else $error("block end on a result that is not last of its item");

    a_trailer_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata[38:8] == '0)
        else $error("primary index or run count set before block end");

    a_ready_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !r_dig_act && (r_tail == 2'd0))
        else $error("input taken while results still pending");

endmodule

`default_nettype wire

// File: sim/tb_mtf_zero_run_encoder.sv
module tb_mtf_zero_run_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import mzr_pkg::*;

    localparam int BLOCK_LEN = DEF_BLOCK_SIZE;

    // one coded byte as it should leave the block
    typedef struct packed {
        t_sym            code;
        logic            item_last;
        logic            block_last;
        logic [PI_W-1:0] primary;
        logic [RC_W-1:0] runs;
    } t_coded;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    wire                    o_s_tready;
    // [7:0] symbol, [22:8] rotation_index, [23] zero
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    // block_end
    logic                   i_s_tlast = 1'b0;
    wire                    o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [7:0] out_byte, [22:8] primary_index, [38:23] run_count, [39] zero
    wire [OUT_TDATA_W-1:0]  o_m_tdata;
    // last_of_item
    wire                    o_m_tlast;
    // [0] end_of_block
    wire [0:0]              o_m_tuser;

    // predicted coder state
    t_sym            mtf_order [ALPHABET_SIZE];
    int              zero_run;
    int              blk_pos;
    logic [PI_W-1:0] primary_pos;
    int              run_total;

    t_coded coded_q[$];
    int     errors = 0;
    int     in_idle_pct = 0;
    int     out_idle_pct = 0;
    int     hold_cnt = 0;

    mtf_zero_run_encoder #(
        .BLOCK_SIZE (BLOCK_LEN)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // mostly short idles, now and then a long one
    function automatic int idle_len(input int pct);
        if ($urandom_range(99) >= pct) return 0;
        if ($urandom_range(9) == 0) return $urandom_range(40, 12);
        return $urandom_range(3, 1);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= 40)
            $display("%0t ns: %s got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic clear_block();
        for (int i = 0; i < ALPHABET_SIZE; i++) mtf_order[i] = t_sym'(i);
        zero_run    = 0;
        blk_pos     = 0;
        primary_pos = '0;
        run_total   = 0;
    endtask

    task automatic push_code(input t_sym b, inout int n_out);
        t_coded c;
        c = '0;
        c.code = b;
        coded_q.push_back(c);
        n_out++;
    endtask

    task automatic count_run();
        if (run_total < COUNT_LIMIT) run_total++;
    endtask

    // pending run of length L goes out as the binary digits of L+1 below its leading one, LSB first
    task automatic flush_zero_run(inout int n_out);
        int v;
        if (zero_run == 0) return;
        count_run();
        v = zero_run + 1;
        do begin
            push_code(t_sym'(v & 1), n_out);
            v = v >> 1;
        end while (v > 1);
        zero_run = 0;
    endtask

    task automatic mtf_encode_item(input t_sym sym, input logic [ROT_W-1:0] rot,
                                   input logic blk_end);
        int     rank;
        int     n_out;
        logic   ends;
        t_coded tail;
        n_out = 0;
        ends = blk_end || (blk_pos >= BLOCK_LEN - 1);
        if (rot == PRIMARY_ROT) primary_pos = blk_pos[PI_W-1:0];
        if (sym == mtf_order[0]) begin
            if (zero_run < RUN_LIMIT) zero_run++;
        end else begin
            flush_zero_run(n_out);
            count_run();
            rank = 1;
            while (mtf_order[rank] != sym) rank++;
            for (int i = rank; i > 0; i--) mtf_order[i] = mtf_order[i-1];
            mtf_order[0] = sym;
            if (rank >= ESC_RANK) begin
                push_code(ESC_BYTE, n_out);
                push_code(t_sym'(rank), n_out);
            end else begin
                push_code(t_sym'(rank + 1), n_out);
            end
        end
        blk_pos++;
        if (ends) begin
            flush_zero_run(n_out);
            if (n_out > 0) begin
                tail = coded_q.pop_back();
                tail.block_last = 1'b1;
                tail.primary    = primary_pos;
                tail.runs       = run_total[RC_W-1:0];
                coded_q.push_back(tail);
            end
            clear_block();
        end
        if (n_out > 0) begin
            tail = coded_q.pop_back();
            tail.item_last = 1'b1;
            coded_q.push_back(tail);
        end
    endtask

    // valid stays up between back-to-back items; it drops only for a gap or in wait_drained
    task automatic send_item(input t_sym sym, input logic [ROT_W-1:0] rot,
                             input logic blk_end);
        int gap;
        gap = idle_len(in_idle_pct);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, rot, sym};
        i_s_tlast  <= blk_end;
        @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
        mtf_encode_item(sym, rot, blk_end);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (coded_q.size() != 0);
    endtask

    always @(posedge i_clk) begin : result_check
        t_coded want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (coded_q.size() == 0) begin
                report_mismatch("result with none pending", o_m_tdata[7:0], 0);
            end else begin
                want = coded_q.pop_front();
                if (o_m_tdata[7:0] !== want.code)
                    report_mismatch("out_byte", o_m_tdata[7:0], want.code);
                if (o_m_tlast !== want.item_last)
                    report_mismatch("last_of_item", o_m_tlast, want.item_last);
                if (o_m_tuser[0] !== want.block_last)
                    report_mismatch("end_of_block", o_m_tuser[0], want.block_last);
                if (o_m_tdata[22:8] !== want.primary)
                    report_mismatch("primary_index", o_m_tdata[22:8], want.primary);
                if (o_m_tdata[38:23] !== want.runs)
                    report_mismatch("run_count", o_m_tdata[38:23], want.runs);
            end
        end
        if (hold_cnt == 0) hold_cnt = idle_len(out_idle_pct);
        if (hold_cnt > 0) begin
            hold_cnt--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic test_runs_and_ranks();
        in_idle_pct  = 20;
        out_idle_pct = 20;
        send_item(8'd0, 15'd0, 1'b0);
        send_item(8'd0, 15'h7FFF, 1'b0);
        send_item(8'd0, PRIMARY_ROT, 1'b0);
        send_item(8'd1, 15'h1234, 1'b0);            // run of 3, then rank 1
        send_item(8'd255, 15'h4321, 1'b0);          // rank 255 escaped
        send_item(mtf_order[254], 15'h0F0F, 1'b0);  // rank 254 escaped
        send_item(mtf_order[253], 15'h70F0, 1'b0);  // highest plain code
        send_item(mtf_order[1], 15'h0001 << 3, 1'b0);
        repeat (5) send_item(mtf_order[0], ROT_W'($urandom_range(32767, 2)), 1'b0);
        send_item(mtf_order[0], 15'h2222, 1'b1);    // block ends on a front hit
    endtask

    task automatic test_block_ends();
        in_idle_pct  = 0;
        out_idle_pct = 0;
        // single-item blocks, no primary seen
        send_item(mtf_order[0], 15'd0, 1'b1);
        send_item(8'd200, 15'h5555, 1'b1);
        // primary seen twice, later one wins; end on a new symbol
        send_item(mtf_order[0], PRIMARY_ROT, 1'b0);
        send_item(8'd9, 15'h2AAA, 1'b0);
        send_item(8'd9, PRIMARY_ROT, 1'b0);
        send_item(8'd7, 15'd0, 1'b0);
        send_item(mtf_order[ALPHABET_SIZE-1], 15'h7FFE, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_blocks(input int n_items);
        int               sent;
        int               blk_len;
        int               pick;
        t_sym             sym;
        logic [ROT_W-1:0] rot;
        logic             fin;
        sent = 0;
        while (sent < n_items) begin
            blk_len = ($urandom_range(7) == 0) ? $urandom_range(90, 30)
                                               : $urandom_range(20, 1);
            case ($urandom_range(3))
                0: begin in_idle_pct = 0;  out_idle_pct = 0;  end
                1: begin in_idle_pct = 20; out_idle_pct = 20; end
                2: begin in_idle_pct = 50; out_idle_pct = 10; end
                default: begin in_idle_pct = 10; out_idle_pct = 60; end
            endcase
            for (int k = 0; k < blk_len && sent < n_items; k++) begin
                pick = $urandom_range(99);
                if (pick < 40)
                    sym = mtf_order[0];
                else if (pick < 70)
                    sym = mtf_order[$urandom_range(5, 1)];
                else if (pick < 80)
                    sym = mtf_order[$urandom_range(ALPHABET_SIZE - 1, 250)];
                else
                    sym = t_sym'($urandom_range(255));
                rot = ($urandom_range(19) == 0) ? PRIMARY_ROT
                                                : ROT_W'($urandom_range(32767));
                fin = (k == blk_len - 1) || (sent == n_items - 1);
                send_item(sym, rot, fin);
                sent++;
                if ($urandom_range(29) == 0) wait_drained();
            end
        end
    endtask

    initial begin
        clear_block();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_runs_and_ranks();
        test_block_ends();
        test_random_blocks(330);
        wait_drained();
        repeat (12) @(posedge i_clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: mtf_zero_run_encoder.f
src/mzr_pkg.sv
src/mzr_cell.sv
src/mzr_row.sv
src/mtf_zero_run_encoder.sv
sim/tb_mtf_zero_run_encoder.sv
